### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. The checks compile away
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

### sv/qisa_pkg.sv
// ----------------------------------------------------------------------------
// qisa_pkg
// Shared types and constants of the query id slot allocator.
// ----------------------------------------------------------------------------
package qisa_pkg;

   // Default table depth.
   localparam int SLOTS_DEF = 32;

   // Fixed field widths.
   localparam int SLOT_W = 5;
   localparam int TIME_W = 32;
   localparam int QID_W  = 16;
   localparam int ADDR_W = 32;
   localparam int PORT_W = 16;
   localparam int TTL_W  = 16;

   // Operation codes of a request beat.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_DONE  = 1'b1;

   // Modes of the shared adder.
   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   // Request beat.
   typedef struct packed {
      logic              op;
      logic [QID_W-1:0]  orig_id;
      logic [ADDR_W-1:0] client_addr;
      logic [PORT_W-1:0] client_port;
      logic [TTL_W-1:0]  ttl;
      logic [TIME_W-1:0] now;
      logic [SLOT_W-1:0] done_slot;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   // Remembered client data of one slot.
   typedef struct packed {
      logic [QID_W-1:0]  orig_id;
      logic [ADDR_W-1:0] client_addr;
      logic [PORT_W-1:0] client_port;
   } slot_info_type;

   // Access controls from the sequencer to the slot store.
   typedef struct packed {
      logic rd_en;
      logic done_we;
      logic done_val;
      logic entry_we;
   } store_ctl_type;

endpackage

### sv/qisa_alu.sv
// ----------------------------------------------------------------------------
// qisa_alu
// Shared 32-bit adder. It adds for the expiry time and subtracts to
// compare a slot expiry against the current time.
// ----------------------------------------------------------------------------
module qisa_alu
   import qisa_pkg::*;
(
   input  logic              mode,
   input  logic [TIME_W-1:0] opa,
   input  logic [TIME_W-1:0] opb,
   output logic [TIME_W-1:0] sum,
   output logic              carry
);

   logic [TIME_W-1:0] opb_mod;
   logic [TIME_W:0]   full;

   // Subtraction is addition of the inverted operand plus one.
   assign opb_mod = (mode == ALU_SUB) ? ~opb : opb;
   assign full    = {1'b0, opa} + {1'b0, opb_mod} + (TIME_W + 1)'(mode == ALU_SUB);
   assign sum     = full[TIME_W-1:0];
   assign carry   = full[TIME_W];

endmodule

### sv/qisa_slot_store.sv
// ----------------------------------------------------------------------------
// qisa_slot_store
// Slot memories: done flag, expiry time and client data, one port shared
// by reads and writes, read data registered.
// ----------------------------------------------------------------------------
module qisa_slot_store
   import qisa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF,
   localparam int IDXW = $clog2(SLOTS)
)(
   input  logic              clock,
   input  store_ctl_type     ctl,
   input  logic [IDXW-1:0]   addr,
   input  logic [TIME_W-1:0] wr_expiry,
   input  slot_info_type     wr_info,
   output logic              rd_done_ff,
   output logic [TIME_W-1:0] rd_expiry_ff
);

   logic              done_mem   [SLOTS];
   logic [TIME_W-1:0] expiry_mem [SLOTS];
   slot_info_type     info_mem   [SLOTS];

   // Writes of a filled slot or a done mark, and the registered scan read.
   always_ff @(posedge clock) begin
      if (ctl.done_we) begin
         done_mem[addr] <= ctl.done_val;
      end
      if (ctl.entry_we) begin
         expiry_mem[addr] <= wr_expiry;
         info_mem[addr]   <= wr_info;
      end
      if (ctl.rd_en) begin
         rd_done_ff   <= done_mem[addr];
         rd_expiry_ff <= expiry_mem[addr];
      end
   end

endmodule

### sv/query_id_slot_allocator_unit.sv
// A mark-done beat passes through the mark and response states before its
// response is registered; an allocate beat first runs the slot scan, which
// reads one slot a cycle from the store and tests it in the shared adder,
// then fills a slot, or answers not-ok when the table is full. One beat is
// handled at a time; a new one is accepted once the previous response is in the output register.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// query_id_slot_allocator_unit
// Pending query slot table of a DNS relay: allocates a slot by reusing the
// first done or expired one, else appending, and marks slots done.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module query_id_slot_allocator_unit
   import qisa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDXW = $clog2(SLOTS);
   localparam int CNTW = $clog2(SLOTS + 1);
   localparam int CMPW = (CNTW > SLOT_W) ? CNTW : SLOT_W;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_MARK = 3'd2;
   localparam logic [2:0] ST_FILL = 3'd3;
   localparam logic [2:0] ST_RESP = 3'd4;

   logic [2:0]        state_ff, state_in;
   req_type           req_ff;
   logic [CNTW-1:0]   scan_idx_ff, scan_idx_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [IDXW-1:0]   chk_idx_ff, chk_idx_in;
   logic [IDXW-1:0]   fill_idx_ff, fill_idx_in;
   logic              append_ff, append_in;
   logic [CNTW-1:0]   used_count_ff, used_count_in;
   logic              res_ok_ff, res_ok_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_accept;
   store_ctl_type     store_ctl;
   logic [IDXW-1:0]   store_addr;
   logic              rd_done;
   logic [TIME_W-1:0] rd_expiry;
   logic              alu_mode;
   logic [TIME_W-1:0] alu_a, alu_b, alu_sum;
   logic              alu_carry;
   logic [TIME_W-1:0] new_expiry;
   slot_info_type     new_info;
   logic [CMPW-1:0]   done_ext, used_ext, fill_ext;
   logic              mark_ok;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Index conversions between the 5-bit fields and the table index.
   assign done_ext = CMPW'(req_ff.done_slot);
   assign used_ext = CMPW'(used_count_ff);
   assign fill_ext = CMPW'(fill_idx_ff);
   assign mark_ok  = (done_ext < used_ext);

   // Expiry saturates when now plus ttl overflows.
   assign new_expiry = alu_carry ? '1 : alu_sum;
   assign new_info   = '{orig_id:     req_ff.orig_id,
                         client_addr: req_ff.client_addr,
                         client_port: req_ff.client_port};

   qisa_slot_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock        (clock),
      .ctl          (store_ctl),
      .addr         (store_addr),
      .wr_expiry    (new_expiry),
      .wr_info      (new_info),
      .rd_done_ff   (rd_done),
      .rd_expiry_ff (rd_expiry)
   );

   qisa_alu u_alu (
      .mode  (alu_mode),
      .opa   (alu_a),
      .opb   (alu_b),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   // Sequencer: scan, fill or mark, then hand the result to the output.
   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      fill_idx_in   = fill_idx_ff;
      append_in     = append_ff;
      used_count_in = used_count_ff;
      res_ok_in     = res_ok_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      store_ctl     = '0;
      store_addr    = fill_idx_ff;
      alu_mode      = ALU_SUB;
      alu_a         = rd_expiry;
      alu_b         = req_ff.now;
      unique case (state_ff)
         ST_IDLE: begin
            scan_idx_in = '0;
            if (req_accept) begin
               state_in = (req_data.op == OP_DONE) ? ST_MARK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The slot read last cycle is tested while the next is read.
            store_addr = scan_idx_ff[IDXW-1:0];
            if (chk_valid_ff && (rd_done || !alu_carry)) begin
               fill_idx_in = chk_idx_ff;
               append_in   = 1'b0;
               state_in    = ST_FILL;
            end else if (scan_idx_ff < used_count_ff) begin
               store_ctl.rd_en = 1'b1;
               chk_valid_in    = 1'b1;
               chk_idx_in      = scan_idx_ff[IDXW-1:0];
               scan_idx_in     = scan_idx_ff + 1'b1;
            end else if (used_count_ff < CNTW'(SLOTS)) begin
               fill_idx_in = used_count_ff[IDXW-1:0];
               append_in   = 1'b1;
               state_in    = ST_FILL;
            end else begin
               res_ok_in   = 1'b0;
               res_slot_in = '0;
               state_in    = ST_RESP;
            end
         end
         ST_MARK: begin
            store_addr         = done_ext[IDXW-1:0];
            store_ctl.done_we  = mark_ok;
            store_ctl.done_val = 1'b1;
            res_ok_in          = mark_ok;
            res_slot_in        = mark_ok ? req_ff.done_slot : '0;
            state_in           = ST_RESP;
         end
         ST_FILL: begin
            alu_mode           = ALU_ADD;
            alu_a              = req_ff.now;
            alu_b              = TIME_W'(req_ff.ttl);
            store_ctl.entry_we = 1'b1;
            store_ctl.done_we  = 1'b1;
            store_ctl.done_val = 1'b0;
            if (append_ff) begin
               used_count_in = used_count_ff + 1'b1;
            end
            res_ok_in   = 1'b1;
            res_slot_in = fill_ext[SLOT_W-1:0];
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{ok: res_ok_ff, slot: res_slot_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_valid_ff  <= 1'b0;
         used_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_valid_ff  <= chk_valid_in;
         used_count_ff <= used_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      fill_idx_ff <= fill_idx_in;
      append_ff   <= append_in;
      res_ok_ff   <= res_ok_in;
      res_slot_ff <= res_slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks of the table bookkeeping.
   `ASSERT_AT(a_count_bound, clock, reset, used_count_ff <= CNTW'(SLOTS), "used count above depth")
   `ASSERT_AT(a_count_stable, clock, reset, (state_ff != ST_FILL) |=> $stable(used_count_ff), "used count changed outside a fill")
   `ASSERT_NEVER(a_read_range, clock, reset, store_ctl.rd_en && (CNTW'(store_addr) >= used_count_ff), "scan read beyond used slots")
   `ASSERT_NEVER(a_slot_range, clock, reset, rsp_valid_ff && rsp_data_ff.ok && (CMPW'(rsp_data_ff.slot) >= used_ext), "granted slot not in use")

endmodule
